FILE: hw/rtl/rgbhsv_pkg.sv
// Shared constants, widths and the two divider steps for the RGB to HSV converter.
`default_nettype none
package rgbhsv_pkg;
    localparam int CHANNEL_BITS  = 8;
    localparam int FRACTION_BITS = 16;

    // hue divisor 6d, and its shifted partial remainder
    localparam int HDIV_BITS = CHANNEL_BITS + 3;
    localparam int HREM_BITS = HDIV_BITS + 1;
    // saturation divisor max, and its shifted partial remainder
    localparam int SREM_BITS = CHANNEL_BITS + 1;
    // signed hue numerator before the wrap
    localparam int HNUM_BITS = CHANNEL_BITS + 4;

    typedef logic [CHANNEL_BITS-1:0]  t_chan;
    typedef logic [FRACTION_BITS-1:0] t_frac;
    typedef logic [HDIV_BITS-1:0]     t_hdiv;
    typedef logic [CHANNEL_BITS-1:0]  t_srem;

    // One restoring division step on the hue divider.
    function automatic t_hdiv hue_rem_step(input t_hdiv rem, input t_hdiv dvs,
                                           output logic qbit);
        logic [HREM_BITS-1:0] sh;
        logic [HREM_BITS-1:0] df;
        begin
            sh = {rem, 1'b0};
            df = sh - {1'b0, dvs};
            qbit = (sh >= {1'b0, dvs});
            hue_rem_step = qbit ? df[HDIV_BITS-1:0] : sh[HDIV_BITS-1:0];
        end
    endfunction

    // One restoring division step on the saturation divider, bringing in one dividend bit.
    function automatic t_srem sat_rem_step(input t_srem rem, input t_chan dvs, input logic nbit,
                                           output logic qbit);
        logic [SREM_BITS-1:0] sh;
        logic [SREM_BITS-1:0] df;
        begin
            sh = {rem, nbit};
            df = sh - {1'b0, dvs};
            qbit = (sh >= {1'b0, dvs});
            sat_rem_step = qbit ? df[CHANNEL_BITS-1:0] : sh[CHANNEL_BITS-1:0];
        end
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/rgb_to_hsv_converter_core.sv
// RGB to HSV converter: pipelined max/min front end and two bit-serial pipelined dividers.
//
//  channel | direction | handshake          | fields
//  --------+-----------+--------------------+--------------------------------------
//  pixel   | in        | i_valid / o_stall  | i_red, i_green, i_blue
//  hsv     | out       | o_valid / i_stall  | o_hue, o_saturation, o_brightness
//
// One pixel is taken every cycle while the output does not stall. The pipeline holds an input register,
// a max/min/numerator stage, then one quotient bit per stage for both
// dividers. Each stage holds only when its successor holds, so bubbles are squeezed out.
// Reset clears the valid bits only. A result held by a stall on the output is never dropped or repeated.
`default_nettype none
module rgb_to_hsv_converter_core (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire  [rgbhsv_pkg::CHANNEL_BITS-1:0]  i_red,
    input  wire  [rgbhsv_pkg::CHANNEL_BITS-1:0]  i_green,
    input  wire  [rgbhsv_pkg::CHANNEL_BITS-1:0]  i_blue,
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic [rgbhsv_pkg::FRACTION_BITS-1:0] o_hue,
    output logic [rgbhsv_pkg::FRACTION_BITS-1:0] o_saturation,
    output logic [rgbhsv_pkg::CHANNEL_BITS-1:0]  o_brightness
);
    import rgbhsv_pkg::*;

    localparam int NS = FRACTION_BITS;

    // input register
    logic  r_v1;
    t_chan r_r, r_g, r_b;

    // divider stages 0..NS
    logic  r_v    [0:NS];
    logic  r_zero [0:NS];
    t_chan r_mx   [0:NS];
    t_hdiv r_hdiv [0:NS];
    t_hdiv r_hrem [0:NS];
    t_frac r_hq   [0:NS];
    t_srem r_srem [0:NS];
    t_frac r_slow [0:NS];
    t_frac r_sq   [0:NS];

    logic [NS:0] en;
    logic        en1;

    assign en[NS] = !r_v[NS] || !i_stall;
    for (genvar k = 0; k < NS; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end
    assign en1     = !r_v1 || en[0];
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_valid;
        end
        if (en1) begin
            r_r <= i_red;
            r_g <= i_green;
            r_b <= i_blue;
        end
    end

    // max, min, spread, wrapped hue numerator, saturation dividend
    t_chan                          mx, mn, d;
    logic signed [HNUM_BITS-1:0]    num;
    t_hdiv                          six_d;
    logic [CHANNEL_BITS+NS-1:0]     sat_n;

    always_comb begin
        mx = r_r;
        mn = r_r;
        if (r_g > mx) mx = r_g;
        if (r_b > mx) mx = r_b;
        if (r_g < mn) mn = r_g;
        if (r_b < mn) mn = r_b;
        d     = mx - mn;
        six_d = HDIV_BITS'({d, 2'b00}) + HDIV_BITS'({d, 1'b0});
        if (r_r == mx) begin
            num = $signed(HNUM_BITS'(r_g)) - $signed(HNUM_BITS'(r_b));
        end else if (r_g == mx) begin
            num = $signed(HNUM_BITS'({d, 1'b0})) + $signed(HNUM_BITS'(r_b))
                - $signed(HNUM_BITS'(r_r));
        end else begin
            num = $signed(HNUM_BITS'({d, 2'b00})) + $signed(HNUM_BITS'(r_r))
                - $signed(HNUM_BITS'(r_g));
        end
        if (num < 0) num = num + $signed(HNUM_BITS'(six_d));
        // d * (2^F - 1) without a multiplier
        sat_n = {d, {NS{1'b0}}} - (CHANNEL_BITS+NS)'(d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en[0]) begin
            r_v[0] <= r_v1;
        end
        if (en[0]) begin
            r_zero[0] <= (d == '0);
            r_mx[0]   <= mx;
            r_hdiv[0] <= six_d;
            r_hrem[0] <= num[HDIV_BITS-1:0];
            r_hq[0]   <= '0;
            r_srem[0] <= sat_n[CHANNEL_BITS+NS-1:NS];
            r_slow[0] <= sat_n[NS-1:0];
            r_sq[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= NS; k++) begin : g_div
        t_hdiv hrem_n;
        t_srem srem_n;
        logic  hbit, sbit;

        always_comb begin
            hrem_n = hue_rem_step(r_hrem[k-1], r_hdiv[k-1], hbit);
            srem_n = sat_rem_step(r_srem[k-1], r_mx[k-1], r_slow[k-1][NS-1], sbit);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= r_v[k-1];
            end
            if (en[k]) begin
                r_zero[k] <= r_zero[k-1];
                r_mx[k]   <= r_mx[k-1];
                r_hdiv[k] <= r_hdiv[k-1];
                r_hrem[k] <= hrem_n;
                r_hq[k]   <= {r_hq[k-1][NS-2:0], hbit};
                r_srem[k] <= srem_n;
                r_slow[k] <= {r_slow[k-1][NS-2:0], 1'b0};
                r_sq[k]   <= {r_sq[k-1][NS-2:0], sbit};
            end
        end
    end

    // grey and black pixels: drop the meaningless quotients
    assign o_valid      = r_v[NS];
    assign o_hue        = r_zero[NS] ? '0 : r_hq[NS];
    assign o_saturation = r_zero[NS] ? '0 : r_sq[NS];
    assign o_brightness = r_mx[NS];
endmodule
`default_nettype wire

FILE: hw/rtl/rgbhsv_checker.sv
// Port-level checker for the RGB to HSV converter, bound to the top level.
`default_nettype none
module rgbhsv_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                o_valid,
    input wire                                i_stall,
    input wire [rgbhsv_pkg::FRACTION_BITS-1:0] o_hue,
    input wire [rgbhsv_pkg::FRACTION_BITS-1:0] o_saturation,
    input wire [rgbhsv_pkg::CHANNEL_BITS-1:0]  o_brightness
);
    import rgbhsv_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_hue) && $stable(o_saturation)
                               && $stable(o_brightness))
        else $error("stalled result changed");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_brightness == t_chan'(0) |-> o_hue == t_frac'(0)
                                                 && o_saturation == t_frac'(0))
        else $error("black pixel with nonzero hue or saturation");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturation == t_frac'(0) |-> o_hue == t_frac'(0))
        else $error("unsaturated pixel with nonzero hue");
endmodule

bind rgb_to_hsv_converter_core rgbhsv_checker u_rgbhsv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_hue        (o_hue),
    .o_saturation (o_saturation),
    .o_brightness (o_brightness)
);
`default_nettype wire
